>>> rtl/core/scr_pkg.sv
// Shared constants, types and helpers of the screen cell style rectangle engine.
package scr_pkg;

   // Grid geometry and style width
   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 256;
   localparam int STYLE_BITS = 32;
   localparam int CELLS      = MAX_ROWS * MAX_COLS;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int RCNT_W = 7;   // rows_in_use register width
   localparam int CCNT_W = 9;   // cols_in_use register width
   localparam int CFG_W  = 9;   // widest register
   localparam int FLD_W  = 11;  // coordinate field width
   localparam int CRD_W  = 13;  // internal signed coordinate width
   localparam int OP_W   = 3;
   localparam int KIND_W = 3;
   localparam int STATE_W = 4;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;
   localparam int REQ_DATA_W = 120;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   localparam logic [RCNT_W-1:0] ROWS_RESET = RCNT_W'(24);
   localparam logic [CCNT_W-1:0] COLS_RESET = CCNT_W'(80);

   // Register indexes
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   // Operation codes on the request side
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
   localparam logic [OP_W-1:0] OP_FILL_RANGE = 3'd1;
   localparam logic [OP_W-1:0] OP_FILL_ROWS  = 3'd2;
   localparam logic [OP_W-1:0] OP_MOVE       = 3'd3;
   localparam logic [OP_W-1:0] OP_READ       = 3'd4;

   // Command kinds handed from front to back
   localparam logic [KIND_W-1:0] K_NOP   = 3'd0;
   localparam logic [KIND_W-1:0] K_CLEAR = 3'd1;
   localparam logic [KIND_W-1:0] K_FILL  = 3'd2;
   localparam logic [KIND_W-1:0] K_MOVE  = 3'd3;
   localparam logic [KIND_W-1:0] K_READ  = 3'd4;

   typedef logic signed [CRD_W-1:0] crd_type;

   // One classified command
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic                  cell_valid;
      logic [STYLE_BITS-1:0] style;
      logic [ROW_W-1:0]      r_lo;
      logic [ROW_W-1:0]      r_hi;
      logic [COL_W-1:0]      c_lo;
      logic [COL_W-1:0]      c_hi;
      logic                  row_ok;
      logic                  col_ok;
      logic                  copy_en;
      logic                  row_desc;
      logic                  col_desc;
      crd_type               dy;
      crd_type               dx;
      logic                  er_en;
      logic [ROW_W-1:0]      er_rlo;
      logic [ROW_W-1:0]      er_rhi;
      logic [COL_W-1:0]      er_clo;
      logic [COL_W-1:0]      er_chi;
      crd_type               dsr;
      crd_type               der;
      crd_type               dsc;
      crd_type               dec;
   } cmd_type;

   // Back-end status seen by the top level
   typedef struct packed {
      logic blk;    // clear pass after reset or register write
   } stat_type;

   function automatic crd_type sx(input logic [FLD_W-1:0] v);
      return crd_type'({{(CRD_W-FLD_W){v[FLD_W-1]}}, v});
   endfunction

   function automatic crd_type smin(input crd_type a, input crd_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic crd_type smax(input crd_type a, input crd_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

>>> rtl/core/screen_cell_style_rect_engine.sv
// Top level of the screen cell style rectangle engine: registers, front, back.
// A 64 x 256 grid of style cells in one memory. Every request word gives one
// response word, in order. The back-end sequencer walks cells one at a time:
// a fill writes one cell a cycle; a move reads and then writes each on-screen
// destination cell whose source is on screen, empties each on-screen
// destination cell whose source is off screen, and then sweeps the on-screen
// source cells for emptying; a clear sweeps all 16384 cells; a read fetches
// one cell. After reset and after each register write a clear pass runs,
// during which req_tready stays low. A two-word queue sits between the
// decoding front end and the sequencer, and a result register sits at the
// output.
module screen_cell_style_rect_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // style[31:0], dst_start_row[42:32], dst_end_row[53:43], dst_start_col[64:54],
   // dst_end_col[75:65], src_start_row[86:76], src_end_row[97:87],
   // src_start_col[108:98], src_end_col[119:109]
   input  logic [scr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation[2:0], style_is_default[3]
   input  logic [scr_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // stored style word[31:0], zero when empty
   output logic [scr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // row_in_range[0], cell_present[1]
   output logic [scr_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [scr_pkg::CFG_W-1:0]        csr_wdata
);
   import scr_pkg::*;

   logic [RCNT_W-1:0] rows_ff, rows_in;
   logic [CCNT_W-1:0] cols_ff, cols_in;
   cmd_type  cmd;
   logic     cmd_valid, cmd_pop;
   stat_type stat;

   // Screen size registers, saturated to the grid
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = (csr_wdata[RCNT_W-1:0] > RCNT_W'(MAX_ROWS)) ?
                                RCNT_W'(MAX_ROWS) : csr_wdata[RCNT_W-1:0];
            CSR_COLS: cols_in = (csr_wdata[CCNT_W-1:0] > CCNT_W'(MAX_COLS)) ?
                                CCNT_W'(MAX_COLS) : csr_wdata[CCNT_W-1:0];
            default: rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   scr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rows       (rows_ff),
      .cols       (cols_ff),
      .blk        (stat.blk),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop)
   );

   scr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .rows       (rows_ff),
      .cols       (cols_ff),
      .cfg_clear  (csr_we),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A register write starts a clear pass that holds off requests
   a_cfg_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("request accepted right after a register write");

   // A present cell always lies on an on-screen row
   a_present_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("cell present on an off-screen row");

   // An empty result carries a zero style
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata == '0))
      else $error("nonzero style on an empty result");

   // The sequencer only takes commands while the queue holds one
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cmd_valid && !stat.blk))
      else $error("command taken from an empty queue");

endmodule

>>> rtl/core/scr_front.sv
// Front end: accepts request words, clips them to the screen and queues commands.
module scr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // style, dst_start_row, dst_end_row, dst_start_col, dst_end_col,
   // src_start_row, src_end_row, src_start_col, src_end_col
   input  logic [scr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation, style_is_default
   input  logic [scr_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic [scr_pkg::RCNT_W-1:0]        rows,
   input  logic [scr_pkg::CCNT_W-1:0]        cols,
   input  logic                              blk,
   output scr_pkg::cmd_type                  cmd,
   output logic                              cmd_valid,
   input  logic                              cmd_pop
);
   import scr_pkg::*;

   logic [OP_W-1:0] op;
   crd_type dsr, der, dsc, dec, ssr, ser, ssc, sec;
   crd_type rows_s, cols_s, rmax, cmax;
   crd_type fa, fb, ra, rb, h, w, cr_lo, cr_hi, cc_lo, cc_hi;
   crd_type er_rlo, er_rhi, er_clo, er_chi, dy, dx;
   logic fr_ok, fw_ok, mv_ok, row_ok, col_ok;
   cmd_type cls;

   cmd_type q_ff [QDEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic push;

   // Field unpacking
   assign op  = req_tuser[OP_W-1:0];
   assign dsr = sx(req_tdata[42:32]);
   assign der = sx(req_tdata[53:43]);
   assign dsc = sx(req_tdata[64:54]);
   assign dec = sx(req_tdata[75:65]);
   assign ssr = sx(req_tdata[86:76]);
   assign ser = sx(req_tdata[97:87]);
   assign ssc = sx(req_tdata[108:98]);
   assign sec = sx(req_tdata[119:109]);

   assign rows_s = crd_type'({{(CRD_W-RCNT_W){1'b0}}, rows});
   assign cols_s = crd_type'({{(CRD_W-CCNT_W){1'b0}}, cols});
   assign rmax   = rows_s - crd_type'(1);
   assign cmax   = cols_s - crd_type'(1);

   // Clipping of fills, moves and reads
   always_comb begin
      fa = smax(dsc, '0);
      fb = smin(dec, cmax);
      fr_ok = (cols != '0) && (dsr >= 0) && (dsr < rows_s) && (dec >= 0) &&
              (dsc < cols_s) && (fa <= fb);
      ra = smax(dsr, '0);
      rb = smin(der, rmax);
      fw_ok = (rows != '0) && (cols != '0) && (der >= 0) && (dsr < rows_s) && (ra <= rb);

      h = smin(der - dsr, ser - ssr);
      w = smin(dec - dsc, sec - ssc);
      mv_ok = (h > 0) && (w > 0);
      cr_lo = smax(dsr, '0);
      cr_hi = smin(dsr + h - crd_type'(1), rmax);
      cc_lo = smax(dsc, '0);
      cc_hi = smin(dsc + w - crd_type'(1), cmax);
      er_rlo = smax(ssr, '0);
      er_rhi = smin(ser - crd_type'(1), rmax);
      er_clo = smax(ssc, '0);
      er_chi = smin(sec - crd_type'(1), cmax);
      dy = dsr - ssr;
      dx = dsc - ssc;

      row_ok = (dsr >= 0) && (dsr < rows_s);
      col_ok = (dsc >= 0) && (dsc < cols_s);

      cls = '0;
      cls.cell_valid = ~req_tuser[OP_W];
      cls.style = req_tdata[STYLE_BITS-1:0];
      cls.dsr = dsr;
      cls.der = der;
      cls.dsc = dsc;
      cls.dec = dec;
      cls.dy = dy;
      cls.dx = dx;
      cls.row_desc = (dy > 0);
      cls.col_desc = (dx > 0);
      unique case (op)
         OP_CLEAR: begin
            cls.kind = K_CLEAR;
         end
         OP_FILL_RANGE: begin
            cls.kind = fr_ok ? K_FILL : K_NOP;
            cls.r_lo = dsr[ROW_W-1:0];
            cls.r_hi = dsr[ROW_W-1:0];
            cls.c_lo = fa[COL_W-1:0];
            cls.c_hi = fb[COL_W-1:0];
         end
         OP_FILL_ROWS: begin
            cls.kind = fw_ok ? K_FILL : K_NOP;
            cls.r_lo = ra[ROW_W-1:0];
            cls.r_hi = rb[ROW_W-1:0];
            cls.c_lo = '0;
            cls.c_hi = cmax[COL_W-1:0];
         end
         OP_MOVE: begin
            cls.kind = mv_ok ? K_MOVE : K_NOP;
            cls.copy_en = mv_ok && (cr_lo <= cr_hi) && (cc_lo <= cc_hi);
            cls.r_lo = cr_lo[ROW_W-1:0];
            cls.r_hi = cr_hi[ROW_W-1:0];
            cls.c_lo = cc_lo[COL_W-1:0];
            cls.c_hi = cc_hi[COL_W-1:0];
            cls.er_en = mv_ok && (er_rlo <= er_rhi) && (er_clo <= er_chi);
            cls.er_rlo = er_rlo[ROW_W-1:0];
            cls.er_rhi = er_rhi[ROW_W-1:0];
            cls.er_clo = er_clo[COL_W-1:0];
            cls.er_chi = er_chi[COL_W-1:0];
         end
         OP_READ: begin
            cls.kind = K_READ;
            cls.row_ok = row_ok;
            cls.col_ok = col_ok;
            cls.r_lo = dsr[ROW_W-1:0];
            cls.c_lo = dsc[COL_W-1:0];
         end
         default: begin
            cls.kind = K_NOP;
         end
      endcase
   end

   // Command queue
   assign req_tready = (cnt_ff != QCNT_W'(QDEPTH)) && !blk;
   assign push      = req_tvalid && req_tready;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + QPTR_W'(1) : wp_ff;
      rp_in  = cmd_pop ? rp_ff + QPTR_W'(1) : rp_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

>>> rtl/core/scr_back.sv
// Back end: cell memory, sweep sequencer for clear, fill, move and read, result register.
module scr_back (
   input  logic                             clock,
   input  logic                             reset,
   input  scr_pkg::cmd_type                 cmd,
   input  logic                             cmd_valid,
   output logic                             cmd_pop,
   input  logic [scr_pkg::RCNT_W-1:0]       rows,
   input  logic [scr_pkg::CCNT_W-1:0]       cols,
   input  logic                             cfg_clear,
   output scr_pkg::stat_type                stat,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [scr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [scr_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import scr_pkg::*;

   localparam logic [STATE_W-1:0] S_IDLE  = 4'd0;
   localparam logic [STATE_W-1:0] S_CLR   = 4'd1;
   localparam logic [STATE_W-1:0] S_FILL  = 4'd2;
   localparam logic [STATE_W-1:0] S_CPRD  = 4'd3;
   localparam logic [STATE_W-1:0] S_CPWR  = 4'd4;
   localparam logic [STATE_W-1:0] S_ERASE = 4'd5;
   localparam logic [STATE_W-1:0] S_RD    = 4'd6;
   localparam logic [STATE_W-1:0] S_RDW   = 4'd7;
   localparam logic [STATE_W-1:0] S_DONE  = 4'd8;

   logic [STYLE_BITS:0] mem [CELLS];
   logic [STYLE_BITS:0] rd_q_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [STYLE_BITS:0] mem_wdata;

   logic [STATE_W-1:0] state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [ROW_W-1:0] cur_r_ff, cur_r_in, wrf_ff, wrf_in, wrl_ff, wrl_in;
   logic [COL_W-1:0] cur_c_ff, cur_c_in, wcf_ff, wcf_in, wcl_ff, wcl_in;
   logic wrdec_ff, wrdec_in, wcdec_ff, wcdec_in;
   logic clr_req_ff, clr_req_in, clr_op_ff, clr_op_in;
   logic res_row_ff, res_row_in, res_pres_ff, res_pres_in;
   logic [STYLE_BITS-1:0] res_style_ff, res_style_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_row_ff, rsp_pres_ff;
   logic [STYLE_BITS-1:0] rsp_style_ff;
   logic rsp_load;

   logic last_c, last_cell, adv, src_ok, in_dst;
   logic [STATE_W-1:0] end_st, cont_st;
   logic [ROW_W-1:0] nxt_r;
   logic [COL_W-1:0] nxt_c;
   crd_type rows_s, cols_s, sr, sc, cr, cc;

   assign rows_s = crd_type'({{(CRD_W-RCNT_W){1'b0}}, rows});
   assign cols_s = crd_type'({{(CRD_W-CCNT_W){1'b0}}, cols});
   assign cr = crd_type'({{(CRD_W-ROW_W){1'b0}}, cur_r_ff});
   assign cc = crd_type'({{(CRD_W-COL_W){1'b0}}, cur_c_ff});
   assign sr = cr - cmd_ff.dy;
   assign sc = cc - cmd_ff.dx;
   assign src_ok = (sr >= 0) && (sr < rows_s) && (sc >= 0) && (sc < cols_s);
   assign in_dst = (cr >= cmd_ff.dsr) && (cr < cmd_ff.der) &&
                   (cc >= cmd_ff.dsc) && (cc < cmd_ff.dec);

   // Rectangle walker
   assign last_c    = (cur_c_ff == wcl_ff);
   assign last_cell = last_c && (cur_r_ff == wrl_ff);
   assign nxt_c = last_c ? wcf_ff : (wcdec_ff ? cur_c_ff - COL_W'(1) : cur_c_ff + COL_W'(1));
   assign nxt_r = !last_c ? cur_r_ff :
                  (wrdec_ff ? cur_r_ff - ROW_W'(1) : cur_r_ff + ROW_W'(1));

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      cur_r_in = cur_r_ff;
      cur_c_in = cur_c_ff;
      wrf_in = wrf_ff;
      wrl_in = wrl_ff;
      wcf_in = wcf_ff;
      wcl_in = wcl_ff;
      wrdec_in = wrdec_ff;
      wcdec_in = wcdec_ff;
      clr_req_in = clr_req_ff || cfg_clear;
      clr_op_in = clr_op_ff;
      res_row_in = res_row_ff;
      res_pres_in = res_pres_ff;
      res_style_in = res_style_ff;
      cmd_pop = 1'b0;
      mem_we = 1'b0;
      mem_waddr = {cur_r_ff, cur_c_ff};
      mem_wdata = '0;
      mem_raddr = {cur_r_ff, cur_c_ff};
      rsp_load = 1'b0;
      adv = 1'b0;
      end_st = S_DONE;
      cont_st = state_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (clr_req_ff) begin
               clr_req_in = cfg_clear;
               clr_op_in = 1'b0;
               state_in = S_CLR;
            end else if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in = cmd;
               clr_op_in = 1'b1;
               res_row_in = 1'b0;
               res_pres_in = 1'b0;
               res_style_in = '0;
               state_in = S_DONE;
               unique case (cmd.kind)
                  K_CLEAR: state_in = S_CLR;
                  K_FILL:  state_in = S_FILL;
                  K_MOVE: begin
                     if (cmd.copy_en) begin
                        state_in = S_CPRD;
                     end else if (cmd.er_en) begin
                        state_in = S_ERASE;
                     end
                  end
                  K_READ:  state_in = S_RD;
                  default: state_in = S_DONE;
               endcase
            end
            // walker bounds for whatever starts
            wrdec_in = 1'b0;
            wcdec_in = 1'b0;
            if (clr_req_ff || (cmd_valid && cmd.kind == K_CLEAR)) begin
               wrf_in = '0;
               wrl_in = ROW_W'(MAX_ROWS - 1);
               wcf_in = '0;
               wcl_in = COL_W'(MAX_COLS - 1);
            end else if (cmd.kind == K_MOVE && cmd.copy_en) begin
               wrdec_in = cmd.row_desc;
               wcdec_in = cmd.col_desc;
               wrf_in = cmd.row_desc ? cmd.r_hi : cmd.r_lo;
               wrl_in = cmd.row_desc ? cmd.r_lo : cmd.r_hi;
               wcf_in = cmd.col_desc ? cmd.c_hi : cmd.c_lo;
               wcl_in = cmd.col_desc ? cmd.c_lo : cmd.c_hi;
            end else if (cmd.kind == K_MOVE) begin
               wrf_in = cmd.er_rlo;
               wrl_in = cmd.er_rhi;
               wcf_in = cmd.er_clo;
               wcl_in = cmd.er_chi;
            end else begin
               wrf_in = cmd.r_lo;
               wrl_in = cmd.r_hi;
               wcf_in = cmd.c_lo;
               wcl_in = cmd.c_hi;
            end
            cur_r_in = wrf_in;
            cur_c_in = wcf_in;
         end
         S_CLR: begin
            mem_we = 1'b1;
            adv = 1'b1;
            end_st = clr_op_ff ? S_DONE : S_IDLE;
         end
         S_FILL: begin
            mem_we = 1'b1;
            mem_wdata = {cmd_ff.cell_valid,
                         cmd_ff.cell_valid ? cmd_ff.style : {STYLE_BITS{1'b0}}};
            adv = 1'b1;
         end
         S_CPRD: begin
            if (src_ok) begin
               mem_raddr = {sr[ROW_W-1:0], sc[COL_W-1:0]};
               state_in = S_CPWR;
            end else begin
               mem_we = 1'b1;
               adv = 1'b1;
            end
            end_st = cmd_ff.er_en ? S_ERASE : S_DONE;
            cont_st = S_CPRD;
         end
         S_CPWR: begin
            mem_we = 1'b1;
            mem_wdata = rd_q_ff;
            adv = 1'b1;
            end_st = cmd_ff.er_en ? S_ERASE : S_DONE;
            cont_st = S_CPRD;
         end
         S_ERASE: begin
            mem_we = !in_dst;
            adv = 1'b1;
         end
         S_RD: begin
            mem_raddr = {cmd_ff.r_lo, cmd_ff.c_lo};
            if (cmd_ff.row_ok && cmd_ff.col_ok) begin
               state_in = S_RDW;
            end else begin
               res_row_in = cmd_ff.row_ok;
               state_in = S_DONE;
            end
         end
         S_RDW: begin
            res_row_in = 1'b1;
            res_pres_in = rd_q_ff[STYLE_BITS];
            res_style_in = rd_q_ff[STYLE_BITS] ? rd_q_ff[STYLE_BITS-1:0] : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // step the walker, or finish the sweep
      if (adv) begin
         if (last_cell) begin
            state_in = end_st;
            if (end_st == S_ERASE) begin
               wrdec_in = 1'b0;
               wcdec_in = 1'b0;
               wrf_in = cmd_ff.er_rlo;
               wrl_in = cmd_ff.er_rhi;
               wcf_in = cmd_ff.er_clo;
               wcl_in = cmd_ff.er_chi;
               cur_r_in = cmd_ff.er_rlo;
               cur_c_in = cmd_ff.er_clo;
            end
         end else begin
            state_in = cont_st;
            cur_r_in = nxt_r;
            cur_c_in = nxt_c;
         end
      end
   end

   // Result register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         clr_req_ff <= 1'b1;
         clr_op_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_req_ff <= clr_req_in;
         clr_op_ff <= clr_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cur_r_ff <= cur_r_in;
      cur_c_ff <= cur_c_in;
      wrf_ff <= wrf_in;
      wrl_ff <= wrl_in;
      wcf_ff <= wcf_in;
      wcl_ff <= wcl_in;
      wrdec_ff <= wrdec_in;
      wcdec_ff <= wcdec_in;
      res_row_ff <= res_row_in;
      res_pres_ff <= res_pres_in;
      res_style_ff <= res_style_in;
      if (rsp_load) begin
         rsp_row_ff <= res_row_ff;
         rsp_pres_ff <= res_pres_ff;
         rsp_style_ff <= res_style_ff;
      end
   end

   // Cell memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_style_ff);
   assign rsp_tuser  = {rsp_pres_ff, rsp_row_ff};
   assign stat.blk   = clr_req_ff || ((state_ff == S_CLR) && !clr_op_ff);

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the screen cell style rectangle engine.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import scr_pkg::*;

   // Unused operation codes, all ignored by the block
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int CYCLE_LIMIT = 4_000_000;

   // Coordinate slots in a command word
   localparam int DSR = 0, DER = 1, DSC = 2, DEC = 3;
   localparam int SSR = 4, SER = 5, SSC = 6, SEC = 7;

   typedef struct {
      logic [OP_W-1:0]       op;
      logic [STYLE_BITS-1:0] style;
      logic                  dflt;
      logic signed [10:0]    crd[8];
   } grid_cmd_type;

   typedef struct {
      logic                  row_in_range;
      logic                  cell_present;
      logic [STYLE_BITS-1:0] style_word;
   } read_back_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_we;
   logic                   csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   screen_cell_style_rect_engine uut (.*);

   // Predicted grid and screen size
   logic                  cell_used [MAX_ROWS][MAX_COLS];
   logic [STYLE_BITS-1:0] cell_word [MAX_ROWS][MAX_COLS];
   logic                  snap_used [MAX_ROWS][MAX_COLS];
   logic [STYLE_BITS-1:0] snap_word [MAX_ROWS][MAX_COLS];
   int rows_on, cols_on;

   read_back_type pending_reads[$];
   int  fail_count = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  cycles = 0;
   int  hold_left = 0;
   bit  smooth = 0;
   int  op_seen[8];

   // Clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------- predictor ----------------
   function automatic void wipe_grid();
      foreach (cell_used[r, c]) begin
         cell_used[r][c] = 0;
         cell_word[r][c] = '0;
      end
   endfunction

   function automatic bit visible(int r, int c);
      return r >= 0 && r < rows_on && c >= 0 && c < cols_on;
   endfunction

   function automatic int pin(int v, int bound);
      int hi;
      hi = bound > 0 ? bound - 1 : 0;
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void paint_span(int row, int sc, int ec, logic used,
                                      logic [STYLE_BITS-1:0] w);
      if (cols_on == 0 || row < 0 || row >= rows_on || ec < 0 || sc >= cols_on) return;
      for (int c = pin(sc, cols_on); c <= pin(ec, cols_on); c++) begin
         cell_used[row][c] = used;
         cell_word[row][c] = used ? w : '0;
      end
   endfunction

   function automatic void shift_rect(grid_cmd_type g);
      int h, w, dr, dc, sr, sc;
      h = g.crd[DER] - g.crd[DSR];
      w = g.crd[DEC] - g.crd[DSC];
      if (g.crd[SER] - g.crd[SSR] < h) h = g.crd[SER] - g.crd[SSR];
      if (g.crd[SEC] - g.crd[SSC] < w) w = g.crd[SEC] - g.crd[SSC];
      if (h <= 0 || w <= 0) return;
      snap_used = cell_used;
      snap_word = cell_word;
      for (int ro = 0; ro < h; ro++)
         for (int co = 0; co < w; co++) begin
            dr = g.crd[DSR] + ro; dc = g.crd[DSC] + co;
            sr = g.crd[SSR] + ro; sc = g.crd[SSC] + co;
            if (visible(dr, dc)) begin
               if (visible(sr, sc)) begin
                  cell_used[dr][dc] = snap_used[sr][sc];
                  cell_word[dr][dc] = snap_word[sr][sc];
               end else begin
                  cell_used[dr][dc] = 0;
                  cell_word[dr][dc] = '0;
               end
            end
         end
      // vacate source cells left outside the destination
      for (int r = g.crd[SSR]; r < g.crd[SER]; r++)
         for (int c = g.crd[SSC]; c < g.crd[SEC]; c++)
            if (visible(r, c) && !(r >= g.crd[DSR] && r < g.crd[DER] &&
                                   c >= g.crd[DSC] && c < g.crd[DEC])) begin
               cell_used[r][c] = 0;
               cell_word[r][c] = '0;
            end
   endfunction

   function automatic read_back_type apply_grid_cmd(grid_cmd_type g);
      read_back_type rb;
      int a, b;
      rb = '{0, 0, '0};
      case (g.op)
         OP_CLEAR: wipe_grid();
         OP_FILL_RANGE: paint_span(g.crd[DSR], g.crd[DSC], g.crd[DEC], !g.dflt, g.style);
         OP_FILL_ROWS: begin
            if (rows_on != 0 && g.crd[DER] >= 0 && g.crd[DSR] < rows_on) begin
               a = pin(g.crd[DSR], rows_on);
               b = pin(g.crd[DER], rows_on);
               for (int r = a; r <= b; r++) paint_span(r, 0, cols_on - 1, !g.dflt, g.style);
            end
         end
         OP_MOVE: shift_rect(g);
         OP_READ: begin
            if (g.crd[DSR] >= 0 && g.crd[DSR] < rows_on) begin
               rb.row_in_range = 1;
               if (g.crd[DSC] >= 0 && g.crd[DSC] < cols_on &&
                   cell_used[g.crd[DSR]][g.crd[DSC]]) begin
                  rb.cell_present = 1;
                  rb.style_word   = cell_word[g.crd[DSR]][g.crd[DSC]];
               end
            end
         end
         default: ;
      endcase
      return rb;
   endfunction

   // ---------------- sender ----------------
   function automatic int gap_len();
      int k;
      if (smooth) return 0;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(grid_cmd_type g);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {g.crd[SEC], g.crd[SSC], g.crd[SER], g.crd[SSR],
                    g.crd[DEC], g.crd[DSC], g.crd[DER], g.crd[DSR], g.style};
      req_tuser  = {g.dflt, g.op};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      pending_reads.push_back(apply_grid_cmd(g));
      op_seen[g.op]++;
      words_sent++;
      @(negedge clock);
   endtask

   function automatic grid_cmd_type make_cmd(logic [OP_W-1:0] op, logic [31:0] sty, logic dflt,
                                          int dsr, int der, int dsc, int dec,
                                          int ssr = 0, int ser = 0, int ssc = 0, int sec = 0);
      grid_cmd_type g;
      g.op = op; g.style = sty; g.dflt = dflt;
      g.crd[DSR] = 11'(dsr); g.crd[DER] = 11'(der);
      g.crd[DSC] = 11'(dsc); g.crd[DEC] = 11'(dec);
      g.crd[SSR] = 11'(ssr); g.crd[SER] = 11'(ser);
      g.crd[SSC] = 11'(ssc); g.crd[SEC] = 11'(sec);
      return g;
   endfunction

   // Wait for every response, then let the block settle
   task automatic drain();
      req_tvalid = 0;
      while (pending_reads.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, int value);
      drain();
      csr_index = idx;
      csr_wdata = CFG_W'(value);
      csr_we    = 1;
      @(negedge clock);
      csr_we    = 0;
      if (idx == CSR_ROWS) rows_on = (value & 'h7f) > MAX_ROWS ? MAX_ROWS : (value & 'h7f);
      else                 cols_on = (value & 'h1ff) > MAX_COLS ? MAX_COLS : (value & 'h1ff);
      wipe_grid();
   endtask

   // ---------------- response checker ----------------
   initial begin
      read_back_type want;
      rsp_tready = 0;
      forever begin
         int stall;
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (pending_reads.size() == 0) begin
               $error("response word with nothing expected");
               fail_count++;
            end else begin
               want = pending_reads.pop_front();
               if (rsp_tuser[0] !== want.row_in_range) begin
                  $error("row_in_range expected %0d got %0d", want.row_in_range, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tuser[1] !== want.cell_present) begin
                  $error("cell_present expected %0d got %0d", want.cell_present, rsp_tuser[1]);
                  fail_count++;
               end
               if (rsp_tdata !== want.style_word) begin
                  $error("stored style expected %h got %h", want.style_word, rsp_tdata);
                  fail_count++;
               end
            end
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 0;
         end else if (smooth) begin
            rsp_tready = 1;
         end else begin
            stall = $urandom_range(0, 199);
            if (stall < 2) begin
               // an occasional long hold-off
               hold_left = $urandom_range(10, 40);
               rsp_tready = 0;
            end else begin
               rsp_tready = (stall >= 50);
            end
         end
      end
   end

   // ---------------- random stimulus ----------------
   function automatic int pick_crd(int bound, bit wild);
      int k;
      k = $urandom_range(0, 19);
      if (wild && k == 0) return $signed(11'($urandom));
      if (wild && k == 1) return $urandom_range(0, 1) ? -1024 : 1023;
      return $urandom_range(0, bound + 5) - 3;
   endfunction

   function automatic grid_cmd_type random_cmd(bit wild);
      grid_cmd_type g;
      int k, h, w, ssr, ssc;
      k = $urandom_range(0, 199);
      g = make_cmd(OP_READ, $urandom, $urandom_range(0, 5) == 0,
                   pick_crd(rows_on, wild), pick_crd(rows_on, wild),
                   pick_crd(cols_on, wild), pick_crd(cols_on, wild));
      if (k < 2 && wild) g.op = OP_CLEAR;
      else if (k < 6) g.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else if (k < 50) begin
         g.op = OP_FILL_RANGE;
      end else if (k < 70) begin
         g.op = OP_FILL_ROWS;
         if ($urandom_range(0, 3) != 0) g.crd[DER] = 11'(g.crd[DSR] + $urandom_range(0, 2));
      end else if (k < 120) begin
         // mostly well-formed moves: small rectangles, nearby destination
         g.op = OP_MOVE;
         h = $urandom_range(1, 4); w = $urandom_range(1, 6);
         ssr = pick_crd(rows_on, wild); ssc = pick_crd(cols_on, wild);
         g.crd[SSR] = 11'(ssr);
         g.crd[SER] = 11'(ssr + h + ($urandom_range(0, 5) == 0));
         g.crd[SSC] = 11'(ssc);
         g.crd[SEC] = 11'(ssc + w - ($urandom_range(0, 5) == 0));
         g.crd[DSR] = 11'(ssr + $urandom_range(0, 6) - 3);
         g.crd[DSC] = 11'(ssc + $urandom_range(0, 8) - 4);
         g.crd[DER] = 11'(g.crd[DSR] + h + $urandom_range(0, 2) - 1);
         g.crd[DEC] = 11'(g.crd[DSC] + w + $urandom_range(0, 2) - 1);
         if (!wild) begin
            g.crd[SER] = 11'(g.crd[SSR] + h);
            g.crd[SEC] = 11'(g.crd[SSC] + w);
         end
      end
      if (!wild && g.op == OP_FILL_ROWS) g.crd[DER] = 11'(g.crd[DSR] + $urandom_range(0, 1));
      return g;
   endfunction

   task automatic random_batch(int rows, int cols, int count, bit wild);
      write_reg(CSR_ROWS, rows);
      write_reg(CSR_COLS, cols);
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) smooth = 1;
         if (i == count / 3 + 40) smooth = 0;
         send_word(random_cmd(wild));
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_directed_default_screen();
      send_word(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
      send_word(make_cmd(OP_FILL_RANGE, 32'hffff_ffff, 0, 0, 0, -1024, 1023));
      send_word(make_cmd(OP_READ, 0, 0, 0, 0, 79, 0));
      send_word(make_cmd(OP_READ, 0, 0, 0, 0, 80, 0));
      send_word(make_cmd(OP_FILL_RANGE, 32'h1234_5678, 1, 0, 0, 5, 7));
      send_word(make_cmd(OP_READ, 0, 0, 0, 0, 6, 0));
      send_word(make_cmd(OP_FILL_RANGE, 32'hdead_beef, 0, 23, 0, 80, 90));
      send_word(make_cmd(OP_FILL_RANGE, 32'hdead_beef, 0, 24, 0, 0, 3));
      send_word(make_cmd(OP_FILL_RANGE, 32'hdead_beef, 0, 3, 0, 0, -1));
      send_word(make_cmd(OP_FILL_ROWS, 32'h0000_0001, 0, 22, 1023, 0, 0));
      send_word(make_cmd(OP_FILL_ROWS, 32'h8000_0000, 0, -1024, 1, 0, 0));
      send_word(make_cmd(OP_READ, 0, 0, 23, 0, 40, 0));
      // overlapping move down and right, then a move partly off screen
      send_word(make_cmd(OP_MOVE, 0, 0, 1, 4, 2, 6, 0, 3, 0, 4));
      send_word(make_cmd(OP_MOVE, 0, 0, 20, 26, 70, 85, 22, 25, 76, 82));
      send_word(make_cmd(OP_MOVE, 0, 0, 5, 5, 0, 4, 0, 3, 0, 4));
      send_word(make_cmd(OP_MOVE, 0, 0, 1023, -1024, 1023, -1024, -1024, 1023, -1024, 1023));
      send_word(make_cmd(OP_READ, 0, 0, 2, 0, 3, 0));
      send_word(make_cmd(OP_READ, 0, 0, -1, 0, 3, 0));
      send_word(make_cmd(OP_READ, 0, 0, 1023, 0, -1024, 0));
      send_word(make_cmd(OP_SPARE_FIRST, 32'hffff_ffff, 1, 0, 1, 0, 1));
      send_word(make_cmd(OP_SPARE_LAST, 32'h5a5a_5a5a, 0, 0, 1, 0, 1));
      send_word(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
      send_word(make_cmd(OP_READ, 0, 0, 23, 0, 79, 0));
   endtask

   task automatic test_zero_sized_screen();
      write_reg(CSR_ROWS, 0);
      send_word(make_cmd(OP_FILL_ROWS, 32'h0f0f_0f0f, 0, 0, 5, 0, 0));
      send_word(make_cmd(OP_FILL_RANGE, 32'h0f0f_0f0f, 0, 0, 0, 0, 5));
      send_word(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
      write_reg(CSR_ROWS, 3);
      write_reg(CSR_COLS, 0);
      send_word(make_cmd(OP_FILL_ROWS, 32'h0f0f_0f0f, 0, 0, 5, 0, 0));
      send_word(make_cmd(OP_MOVE, 0, 0, 1, 2, 1, 2, 0, 1, 0, 1));
      send_word(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_full_screen();
      write_reg(CSR_ROWS, 127);
      write_reg(CSR_COLS, 511);
      send_word(make_cmd(OP_FILL_ROWS, 32'hcafe_f00d, 0, 62, 1023, 0, 0));
      send_word(make_cmd(OP_READ, 0, 0, 63, 0, 255, 0));
      send_word(make_cmd(OP_READ, 0, 0, 64, 0, 255, 0));
      send_word(make_cmd(OP_MOVE, 0, 0, 61, 63, 250, 256, 62, 64, 252, 258));
      send_word(make_cmd(OP_READ, 0, 0, 62, 0, 250, 0));
      for (int i = 0; i < 60; i++) send_word(random_cmd(0));
   endtask

   task automatic test_backpressure();
      write_reg(CSR_ROWS, 6);
      write_reg(CSR_COLS, 10);
      smooth = 1;
      hold_left = 400;
      for (int i = 0; i < 30; i++) send_word(random_cmd(0));
      smooth = 0;
   endtask

   initial begin
      reset = 1; req_tvalid = 0; req_tdata = '0; req_tuser = '0;
      csr_we = 0; csr_index = CSR_ROWS; csr_wdata = '0;
      rows_on = ROWS_RESET; cols_on = COLS_RESET;
      wipe_grid();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_directed_default_screen();
      test_zero_sized_screen();
      test_full_screen();
      test_backpressure();
      random_batch(8, 16, 500, 1);
      random_batch(1, 1, 150, 1);
      random_batch(5, 33, 450, 1);
      random_batch(64, 3, 350, 1);
      random_batch(12, 40, 250, 1);

      drain();
      $display("Sent %0d words (clear %0d, fill %0d, rows %0d, move %0d, read %0d), checked %0d.",
               words_sent, op_seen[OP_CLEAR], op_seen[OP_FILL_RANGE], op_seen[OP_FILL_ROWS],
               op_seen[OP_MOVE], op_seen[OP_READ], words_checked);
      $display("Screens from zero size to full 64x256, with stalls and a long output hold-off.");
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/scr_pkg.sv
rtl/core/scr_front.sv
rtl/core/scr_back.sv
rtl/core/screen_cell_style_rect_engine.sv
sim/tb_top.sv
